/* src/uvar_pkg.sv */
`default_nettype none
package uvar_pkg;

	localparam int COUNT_BITS_DEF    = 20;
	localparam int UVI_FRAC_BITS_DEF = 8;

	localparam int RAW_W  = 20;
	localparam int UVI_W  = 24;
	localparam int PCT_W  = 7;
	localparam int WF_W   = 12;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 12;
	localparam int DEN_W  = 19;
	localparam int RBITS_W = 5;

	localparam logic [IDX_W-1:0] MAX_GAIN = 3'd4;
	localparam logic [IDX_W-1:0] MAX_RES  = 3'd5;

	localparam logic [PCT_W-1:0] LOW_PCT_RST  = 7'd10;
	localparam logic [PCT_W-1:0] HIGH_PCT_RST = 7'd90;
	localparam logic [WF_W-1:0]  WF_RST       = 12'd256;
	localparam logic [IDX_W-1:0] GAIN_RST     = 3'd1;
	localparam logic [IDX_W-1:0] RES_RST      = 3'd3;

	localparam logic [IDX_W-1:0] REG_LOW_PCT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_HIGH_PCT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_WIN       = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_GAIN = 3'd3;
	localparam logic [IDX_W-1:0] REG_START_RES  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_LOW,
		ST_DIV,
		ST_RANGE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             data_ready;
		logic [RAW_W-1:0] raw_count;
		logic             range_en;
	} in_t;

	typedef struct packed {
		logic [UVI_W-1:0] uv_index;
		logic             has_reading;
		logic [RAW_W-1:0] last_raw_count;
		logic [IDX_W-1:0] gain_step;
		logic [IDX_W-1:0] resolution_step;
		logic             range_changed;
	} out_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// 23 * gain * t2, with t2 = 25 << r
	function automatic logic [DEN_W-1:0] den_base(input logic [IDX_W-1:0] g,
		input logic [IDX_W-1:0] r);
		logic [DEN_W-1:0] base;
		case (g)
			3'd0: base = 19'd575;
			3'd1: base = 19'd1725;
			3'd2: base = 19'd3450;
			3'd3: base = 19'd5175;
			default: base = 19'd10350;
		endcase
		return base << r;
	endfunction

	function automatic logic [RBITS_W-1:0] res_bits(input logic [IDX_W-1:0] r);
		logic [RBITS_W-1:0] b;
		case (r)
			3'd0: b = 5'd13;
			3'd1: b = 5'd16;
			3'd2: b = 5'd17;
			3'd3: b = 5'd18;
			3'd4: b = 5'd19;
			default: b = 5'd20;
		endcase
		return b;
	endfunction

	function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v,
		input logic [IDX_W-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

endpackage
`default_nettype wire

/* src/uvar_div.sv */
`default_nettype none
module uvar_div #(
	parameter int NUM_W = 40
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire uvar_pkg::div_ctl_t            ctl,
	input  wire logic [NUM_W-1:0]              dividend,
	input  wire logic [uvar_pkg::DEN_W-1:0]    divisor,
	output uvar_pkg::div_sts_t                 sts,
	output logic [uvar_pkg::UVI_W-1:0]         quotient
);

	localparam int DenW = uvar_pkg::DEN_W;
	localparam int QW   = uvar_pkg::UVI_W;
	localparam int CntW = $clog2(NUM_W + 1);

	logic [CntW-1:0]  cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] num_q;
	logic [DenW-1:0]  den_q;
	logic [DenW-1:0]  rem_q;
	logic [QW-1:0]    quo_q;
	logic             ovf_q;

	logic [DenW:0]    rem_sh;
	logic [DenW:0]    diff;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		fits   = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CntW'(1));
			if (ctl.start) begin
				cnt_q <= CntW'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[DenW-1:0] : rem_sh[DenW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
			ovf_q <= ovf_q | quo_q[QW-1];
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign quotient = ovf_q ? {QW{1'b1}} : quo_q;

endmodule
`default_nettype wire

/* src/uv_index_autorange.sv */
// UV index with automatic gain and resolution ranging.
//
// Input channel (in_valid / in_stall / in_data): one request per sensor poll.
// With data_ready set the count is converted to a UV index under the gain and
// resolution in force, then, with range_en set, the range may step by one.
// Output channel (out_valid / out_stall / out_data): one result per request.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge.
//
// A poll with data_ready set runs the multiply, scale, low-threshold, divide
// and range steps before its result register load; the restoring divider
// retires one quotient bit per cycle. A poll without new data goes straight
// to the result register. The next request is accepted in the cycle after
// the result is loaded. One request is in flight at a time; in_stall is
// high while it is worked on.
// The result sits in an output register, so the next request is accepted while
// a result is held by out_stall; a finished request then waits until the
// output register frees.
// Reset (arst_n low) restores the register defaults, gain step 1, resolution
// step 3, and clears the last reading and any held result.
`default_nettype none
module uv_index_autorange #(
	parameter int COUNT_BITS    = uvar_pkg::COUNT_BITS_DEF,
	parameter int UVI_FRAC_BITS = uvar_pkg::UVI_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [uvar_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [uvar_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire uvar_pkg::in_t               in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output uvar_pkg::out_t                   out_data
);

	localparam int CB    = COUNT_BITS;
	localparam int WfW   = uvar_pkg::WF_W;
	localparam int PctW  = uvar_pkg::PCT_W;
	localparam int IdxW  = uvar_pkg::IDX_W;
	localparam int RawW  = uvar_pkg::RAW_W;
	localparam int UviW  = uvar_pkg::UVI_W;
	localparam int DenW  = uvar_pkg::DEN_W;
	localparam int RbW   = uvar_pkg::RBITS_W;
	localparam int ProdW = CB + WfW;
	localparam int WideW = CB + 20 + UVI_FRAC_BITS;
	localparam int NumW  = WideW - 8;

	uvar_pkg::state_t state_q, state_d;

	logic [PctW-1:0] low_q, high_q;
	logic [WfW-1:0]  wf_q;
	logic [IdxW-1:0] gain_q, res_q;
	logic [RawW-1:0] last_cnt_q;
	logic [UviW-1:0] uvi_q;
	logic            seen_q;
	logic            changed_q;

	logic [CB-1:0]   cnt_q;
	logic            auto_q;
	logic [ProdW-1:0] prod_q, hi_q, lo_q;
	logic [NumW-1:0] num_q;
	logic [DenW-1:0] den_q;

	logic            out_valid_q;
	uvar_pkg::out_t  out_q;

	logic            accept;
	logic            load_out;
	logic            sel_cnt;
	logic            sel_high;
	uvar_pkg::div_ctl_t div_ctl;
	uvar_pkg::div_sts_t div_sts;
	logic [UviW-1:0] div_quo;

	logic [CB-1:0]   mul_a;
	logic [WfW-1:0]  mul_b;
	logic [ProdW-1:0] mul_p;
	logic [WideW-1:0] wide;
	logic [RbW-1:0]  rbits;
	logic [CB-1:0]   fs;
	logic [ProdW-1:0] c100;
	logic            over_hi, under_lo, at_top, lower, raise;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvar_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		accept      = 1'b0;
		load_out    = 1'b0;
		sel_cnt     = 1'b0;
		sel_high    = 1'b0;
		div_ctl.start = 1'b0;
		case (state_q)
			uvar_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = in_data.data_ready ? uvar_pkg::ST_MUL : uvar_pkg::ST_DONE;
				end
			end
			uvar_pkg::ST_MUL: begin
				sel_cnt = 1'b1;
				state_d = uvar_pkg::ST_SCALE;
			end
			uvar_pkg::ST_SCALE: begin
				sel_high = 1'b1;
				state_d  = uvar_pkg::ST_LOW;
			end
			uvar_pkg::ST_LOW: begin
				div_ctl.start = 1'b1;
				state_d       = uvar_pkg::ST_DIV;
			end
			uvar_pkg::ST_DIV: begin
				if (div_sts.done) begin
					state_d = uvar_pkg::ST_RANGE;
				end
			end
			uvar_pkg::ST_RANGE: begin
				state_d = uvar_pkg::ST_DONE;
			end
			uvar_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = uvar_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = uvar_pkg::ST_IDLE;
			end
		endcase
	end

	// shared multiplier: count * window, then full scale * percent
	always_comb begin
		mul_a = sel_cnt ? cnt_q : fs;
		if (sel_cnt) begin
			mul_b = wf_q;
		end else if (sel_high) begin
			mul_b = WfW'(high_q);
		end else begin
			mul_b = WfW'(low_q);
		end
		mul_p = ProdW'(mul_a) * ProdW'(mul_b);
	end

	always_comb begin
		wide  = ((WideW'(prod_q) << 7) + (WideW'(prod_q) << 4)) << UVI_FRAC_BITS;
		rbits = uvar_pkg::res_bits(res_q);
		if (rbits >= RbW'(CB)) begin
			fs = '1;
		end else begin
			fs = {CB{1'b1}} >> (RbW'(CB) - rbits);
		end
		c100     = (ProdW'(cnt_q) << 6) + (ProdW'(cnt_q) << 5) + (ProdW'(cnt_q) << 2);
		at_top   = cnt_q >= fs;
		over_hi  = (c100 > hi_q) && !at_top;
		under_lo = c100 < lo_q;
		lower    = over_hi || (!under_lo && at_top);
		raise    = !over_hi && under_lo;
	end

	uvar_div #(
		.NUM_W(NumW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.dividend(num_q),
		.divisor (den_q),
		.sts     (div_sts),
		.quotient(div_quo)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q  <= in_data.raw_count[CB-1:0];
			auto_q <= in_data.range_en;
		end
		case (state_q)
			uvar_pkg::ST_MUL: begin
				prod_q <= mul_p;
			end
			uvar_pkg::ST_SCALE: begin
				num_q <= wide[WideW-1:8];
				den_q <= uvar_pkg::den_base(gain_q, res_q);
				hi_q  <= mul_p;
			end
			uvar_pkg::ST_LOW: begin
				lo_q <= mul_p;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= uvar_pkg::LOW_PCT_RST;
			high_q     <= uvar_pkg::HIGH_PCT_RST;
			wf_q       <= uvar_pkg::WF_RST;
			gain_q     <= uvar_pkg::GAIN_RST;
			res_q      <= uvar_pkg::RES_RST;
			last_cnt_q <= '0;
			uvi_q      <= '0;
			seen_q     <= 1'b0;
			changed_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					uvar_pkg::REG_LOW_PCT: low_q <= cfg_data[PctW-1:0];
					uvar_pkg::REG_HIGH_PCT: high_q <= cfg_data[PctW-1:0];
					uvar_pkg::REG_WIN: begin
						if (cfg_data[WfW-1:0] != '0) begin
							wf_q <= cfg_data[WfW-1:0];
						end
					end
					uvar_pkg::REG_START_GAIN:
						gain_q <= uvar_pkg::clamp_idx(cfg_data[IdxW-1:0], uvar_pkg::MAX_GAIN);
					uvar_pkg::REG_START_RES:
						res_q <= uvar_pkg::clamp_idx(cfg_data[IdxW-1:0], uvar_pkg::MAX_RES);
					default: begin
					end
				endcase
			end
			if (accept) begin
				changed_q <= 1'b0;
			end
			if (state_q == uvar_pkg::ST_DIV && div_sts.done) begin
				uvi_q      <= div_quo;
				last_cnt_q <= RawW'(cnt_q);
				seen_q     <= 1'b1;
			end
			if (state_q == uvar_pkg::ST_RANGE && auto_q) begin
				if (lower) begin
					if (gain_q != '0) begin
						gain_q    <= gain_q - IdxW'(1);
						changed_q <= 1'b1;
					end else if (res_q != '0) begin
						res_q     <= res_q - IdxW'(1);
						changed_q <= 1'b1;
					end
				end else if (raise) begin
					if (res_q < uvar_pkg::MAX_RES) begin
						res_q     <= res_q + IdxW'(1);
						changed_q <= 1'b1;
					end else if (gain_q < uvar_pkg::MAX_GAIN) begin
						gain_q    <= gain_q + IdxW'(1);
						changed_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.uv_index        <= uvi_q;
			out_q.has_reading     <= seen_q;
			out_q.last_raw_count  <= last_cnt_q;
			out_q.gain_step       <= gain_q;
			out_q.resolution_step <= res_q;
			out_q.range_changed   <= changed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_range_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we && state_q != uvar_pkg::ST_RANGE |=> $stable(gain_q) && $stable(res_q))
		else $error("range moved outside the range step");

	a_no_change_manual: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == uvar_pkg::ST_RANGE && !auto_q |=> !changed_q)
		else $error("range change flagged with auto range off");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == uvar_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider restarted while busy");

	a_idx_limit: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_q.gain_step <= uvar_pkg::MAX_GAIN
			&& out_q.resolution_step <= uvar_pkg::MAX_RES)
		else $error("range index out of bounds");
`endif

endmodule
`default_nettype wire
